[design/rrfifo_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrfifo_pkg
// Shared types and constants for the record ring FIFO with peek.
// ----------------------------------------------------------------------------
package rrfifo_pkg;

  // Default sizes
  localparam int RecordBitsDef = 32;
  localparam int SlotsDef      = 256;

  // Capacity register and ring sizing
  localparam int CAP_W  = 8;          // capacity, pointers, fill count
  localparam int RING_W = CAP_W + 1;  // ring size holds capacity + 1
  localparam logic [CAP_W-1:0] CAP_RESET = 8'd255;

  // Operation codes
  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_PEEK  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Pointer unit decision for the transaction being offered
  typedef struct packed {
    status_e            status;
    logic               mem_wr;
    logic               mem_rd;
    logic [CAP_W-1:0]   wr_slot;
    logic [CAP_W-1:0]   rd_slot;
    logic [CAP_W-1:0]   fill;
    logic               is_empty;
    logic               is_full;
  } ptr_res_t;

endpackage

[design/rrfifo_ptr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrfifo_ptr
// Read/write pointers, fill count and ring size. Decides status, memory
// access slots and the post-operation flags for the offered transaction and
// updates the pointers when it is accepted.
// ----------------------------------------------------------------------------
module rrfifo_ptr #(
  parameter int SLOTS = rrfifo_pkg::SlotsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  rrfifo_pkg::func_e          func_i,
  input  logic [rrfifo_pkg::CAP_W-1:0] peek_index_i,
  input  logic                       cfg_we_i,
  input  logic [rrfifo_pkg::CAP_W-1:0] cfg_wdata_i,
  output rrfifo_pkg::ptr_res_t       res_o
);
  import rrfifo_pkg::*;

  // Ring size after reset: capacity 255 plus one, limited by the store
  localparam int RingRst = (SLOTS < 256) ? SLOTS : 256;

  logic [CAP_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CAP_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [CAP_W-1:0]  fill_q, fill_d;
  logic [RING_W-1:0] ring_q, ring_d;

  logic [RING_W-1:0] ring_cfg;
  logic [RING_W-1:0] rd_inc, wr_inc, peek_sum;
  logic              at_full, at_empty;

  // Ring size for a new capacity: capacity + 1, clipped to the store depth
  always_comb begin
    ring_cfg = {1'b0, cfg_wdata_i} + RING_W'(1);
    if (32'(ring_cfg) > 32'(SLOTS)) begin
      ring_cfg = RING_W'(SLOTS);
    end
  end

  // Wrapping increments and the peek slot (sum stays below twice the ring for an in-range index)
  always_comb begin
    rd_inc   = {1'b0, rd_ptr_q} + RING_W'(1);
    wr_inc   = {1'b0, wr_ptr_q} + RING_W'(1);
    peek_sum = {1'b0, rd_ptr_q} + {1'b0, peek_index_i};
    if (rd_inc == ring_q) rd_inc = '0;
    if (wr_inc == ring_q) wr_inc = '0;
    if (peek_sum >= ring_q) peek_sum = peek_sum - ring_q;
  end

  assign at_full  = ({1'b0, fill_q} == (ring_q - RING_W'(1)));
  assign at_empty = (fill_q == '0);

  // Operation decode and next pointer state
  always_comb begin
    res_o          = '0;
    res_o.status   = ST_OK;
    res_o.wr_slot  = wr_ptr_q;
    res_o.rd_slot  = rd_ptr_q;
    rd_ptr_d       = rd_ptr_q;
    wr_ptr_d       = wr_ptr_q;
    fill_d         = fill_q;
    ring_d         = ring_q;

    case (func_i)
      FUNC_WRITE: begin
        if (at_full) begin
          res_o.status = ST_FULL;
        end else begin
          res_o.mem_wr = 1'b1;
          wr_ptr_d     = wr_inc[CAP_W-1:0];
          fill_d       = fill_q + CAP_W'(1);
        end
      end
      FUNC_READ: begin
        if (at_empty) begin
          res_o.status = ST_EMPTY;
        end else begin
          res_o.mem_rd = 1'b1;
          rd_ptr_d     = rd_inc[CAP_W-1:0];
          fill_d       = fill_q - CAP_W'(1);
        end
      end
      FUNC_PEEK: begin
        if (peek_index_i >= fill_q) begin
          res_o.status = ST_RANGE;
        end else begin
          res_o.mem_rd  = 1'b1;
          res_o.rd_slot = peek_sum[CAP_W-1:0];
        end
      end
      FUNC_CLEAR: begin
        rd_ptr_d = '0;
        wr_ptr_d = '0;
        fill_d   = '0;
      end
      default: begin
        res_o.status = ST_OK;
      end
    endcase

    res_o.fill     = fill_d;
    res_o.is_empty = (fill_d == '0);
    res_o.is_full  = ({1'b0, fill_d} == (ring_q - RING_W'(1)));

    if (!accept_i) begin
      rd_ptr_d = rd_ptr_q;
      wr_ptr_d = wr_ptr_q;
      fill_d   = fill_q;
    end

    // Capacity write sets the ring size and clears the pointers
    if (cfg_we_i) begin
      ring_d   = ring_cfg;
      rd_ptr_d = '0;
      wr_ptr_d = '0;
      fill_d   = '0;
    end
  end

  // Pointer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      fill_q   <= '0;
      ring_q   <= RING_W'(RingRst);
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
      ring_q   <= ring_d;
    end
  end

endmodule

[design/record_ring_fifo_with_peek.sv]
// ----------------------------------------------------------------------------
// record_ring_fifo_with_peek
// A result is offered once its transaction has passed the read stage (record
// memory read at the accept edge) and then the output register.
// Throughput: one transaction per cycle while the output is not stalled; the
// pointer unit updates at accept so the next operation sees it at once.
// Reset: pointers and fill count zero, capacity 255; record memory not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module record_ring_fifo_with_peek #(
  parameter int RECORD_BITS = rrfifo_pkg::RecordBitsDef,
  parameter int SLOTS       = rrfifo_pkg::SlotsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [rrfifo_pkg::CAP_W-1:0] cfg_wdata_i,
  // operation channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   func_i,
  input  logic [RECORD_BITS-1:0]       record_in_i,
  input  logic [rrfifo_pkg::CAP_W-1:0] peek_index_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [RECORD_BITS-1:0]       record_out_o,
  output logic [rrfifo_pkg::CAP_W-1:0] fill_count_o,
  output logic                         is_empty_o,
  output logic                         is_full_o
);
  import rrfifo_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  ptr_res_t res;
  logic     accept;
  logic     s1_move;

  // Read stage registers
  logic                   s1_valid_q;
  status_e                s1_status_q;
  logic                   s1_rd_q;
  logic [CAP_W-1:0]       s1_fill_q;
  logic                   s1_empty_q;
  logic                   s1_full_q;

  // Record memory
  logic [RECORD_BITS-1:0] mem_q [SLOTS];
  logic [RECORD_BITS-1:0] mem_rdata_q;

  // Output registers
  logic                   out_valid_q;
  status_e                out_status_q;
  logic [RECORD_BITS-1:0] out_record_q;
  logic [CAP_W-1:0]       out_fill_q;
  logic                   out_empty_q;
  logic                   out_full_q;

  // Handshake: the read stage advances when the output register frees up
  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign accept     = in_valid_i && !in_stall_o;

  rrfifo_ptr #(
    .SLOTS (SLOTS)
  ) u_ptr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .func_i       (func_e'(func_i)),
    .peek_index_i (peek_index_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .res_o        (res)
  );

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (accept && res.mem_wr) begin
      mem_q[AW'(res.wr_slot)] <= record_in_i;
    end
    if (accept && res.mem_rd) begin
      mem_rdata_q <= mem_q[AW'(res.rd_slot)];
    end
  end

  // Read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Read stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= res.status;
      s1_rd_q     <= res.mem_rd;
      s1_fill_q   <= res.fill;
      s1_empty_q  <= res.is_empty;
      s1_full_q   <= res.is_full;
    end
  end

  // Output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload; record is zero unless the memory was read
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_status_q <= s1_status_q;
      out_record_q <= s1_rd_q ? mem_rdata_q : '0;
      out_fill_q   <= s1_fill_q;
      out_empty_q  <= s1_empty_q;
      out_full_q   <= s1_full_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign record_out_o = out_record_q;
  assign fill_count_o = out_fill_q;
  assign is_empty_o   = out_empty_q;
  assign is_full_o    = out_full_q;

endmodule

[design/rrfifo_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrfifo_chk
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rrfifo_chk #(
  parameter int RECORD_BITS = rrfifo_pkg::RecordBitsDef
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [1:0]                   status_o,
  input logic [RECORD_BITS-1:0]       record_out_o,
  input logic [rrfifo_pkg::CAP_W-1:0] fill_count_o,
  input logic                         is_empty_o,
  input logic                         is_full_o
);
  import rrfifo_pkg::*;

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(record_out_o) && $stable(fill_count_o))
    else $error("stalled result changed");

  // Refused transactions carry no record
  a_rec_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (record_out_o == '0))
    else $error("record on refused transaction");

  // Empty flag agrees with fill count
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (fill_count_o == '0)))
    else $error("empty flag mismatch");

  // Read refused only when empty
  a_st_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> is_empty_o)
    else $error("empty status while holding records");

  // Write refused only when full
  a_st_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> is_full_o)
    else $error("full status while not full");

endmodule

bind record_ring_fifo_with_peek rrfifo_chk #(
  .RECORD_BITS (RECORD_BITS)
) u_rrfifo_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .record_out_o (record_out_o),
  .fill_count_o (fill_count_o),
  .is_empty_o   (is_empty_o),
  .is_full_o    (is_full_o)
);

[test/record_ring_fifo_with_peek_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_ring_fifo_with_peek_tb
// Self-checking bench for the record ring FIFO with peek. A cycle-level model
// of the ring (store, pointers, capacity) predicts the result of every
// accepted transaction. A checker compares each accepted result field by
// field with the oldest prediction. Directed tests cover the empty and full
// edges, zero records on non-data results and the single-slot ring. Random
// traffic then fills and drains rings of several capacities, while both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module record_ring_fifo_with_peek_tb;
  import rrfifo_pkg::*;

  localparam int RecBits   = RecordBitsDef;
  localparam int SlotCount = SlotsDef;

  typedef struct packed {
    status_e            status;
    logic [RecBits-1:0] record;
    logic [CAP_W-1:0]   fill;
    logic               empty;
    logic               full;
  } ring_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CAP_W-1:0]   cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         func_i;
  logic [RecBits-1:0] record_in_i;
  logic [CAP_W-1:0]   peek_index_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         status_o;
  logic [RecBits-1:0] record_out_o;
  logic [CAP_W-1:0]   fill_count_o;
  logic               is_empty_o;
  logic               is_full_o;

  // Ring mirror used for prediction
  logic [RecBits-1:0] ring_mem [SlotCount];
  int unsigned        rd_ptr = 0;
  int unsigned        wr_ptr = 0;
  int unsigned        ring_cap = CAP_RESET;
  int unsigned        current_fill = 0;

  ring_result_t       pending_results [$];
  int unsigned        mismatch_count = 0;
  bit                 no_idle = 1'b0;

  record_ring_fifo_with_peek dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .record_in_i  (record_in_i),
    .peek_index_i (peek_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .record_out_o (record_out_o),
    .fill_count_o (fill_count_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o)
  );

  always #10 clk_i = ~clk_i;

  // Apply one operation to the ring mirror and return its result
  function automatic ring_result_t apply_ring_op(func_e op, logic [RecBits-1:0] rec,
                                                 int unsigned idx);
    ring_result_t res;
    int unsigned  n;
    int unsigned  fill;
    n = ring_cap + 1;
    if (n > SlotCount) n = SlotCount;
    res.status = ST_OK;
    res.record = '0;
    case (op)
      FUNC_WRITE: begin
        if ((wr_ptr + 1) % n == rd_ptr) begin
          res.status = ST_FULL;
        end else begin
          ring_mem[wr_ptr % SlotCount] = rec;
          wr_ptr = (wr_ptr + 1) % n;
        end
      end
      FUNC_READ: begin
        if (rd_ptr == wr_ptr) begin
          res.status = ST_EMPTY;
        end else begin
          res.record = ring_mem[rd_ptr % SlotCount];
          rd_ptr = (rd_ptr + 1) % n;
        end
      end
      FUNC_PEEK: begin
        if (idx >= (n + wr_ptr - rd_ptr) % n) res.status = ST_RANGE;
        else res.record = ring_mem[((idx + rd_ptr) % n) % SlotCount];
      end
      default: begin
        rd_ptr = 0;
        wr_ptr = 0;
      end
    endcase
    fill = (n + wr_ptr - rd_ptr) % n;
    current_fill = fill;
    res.fill  = fill[CAP_W-1:0];
    res.empty = (fill == 0);
    res.full  = (fill == n - 1);
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Wait count for one transaction on either side
  function automatic int unsigned draw_wait();
    if (no_idle) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Check accepted results, track configuration and predict accepted operations
  always @(posedge clk_i) begin : result_check
    ring_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no transaction pending");
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
          if (record_out_o !== want.record)
            report_mismatch($sformatf("record %h, expected %h", record_out_o, want.record));
          if (fill_count_o !== want.fill)
            report_mismatch($sformatf("fill %0d, expected %0d", fill_count_o, want.fill));
          if (is_empty_o !== want.empty)
            report_mismatch($sformatf("empty %b, expected %b", is_empty_o, want.empty));
          if (is_full_o !== want.full)
            report_mismatch($sformatf("full %b, expected %b", is_full_o, want.full));
        end
      end
      if (cfg_we_i) begin
        ring_cap     = cfg_wdata_i;
        rd_ptr       = 0;
        wr_ptr       = 0;
        current_fill = 0;
      end
      if (in_valid_i && !in_stall_o)
        pending_results.push_back(apply_ring_op(func_e'(func_i), record_in_i, peek_index_i));
    end
  end

  // Result side: stall a random number of cycles before taking each result
  initial begin : result_sink
    int unsigned hold;
    forever begin
      hold = draw_wait();
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!(out_valid_o && rst_ni)) @(posedge clk_i);
    end
  end

  // Send one transaction; returns at the edge where it is accepted
  task automatic issue_op(func_e op, logic [RecBits-1:0] rec, logic [CAP_W-1:0] idx);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= op;
    record_in_i  <= rec;
    peek_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Stop sending and wait until every predicted result has been taken
  task automatic drain_ring_traffic();
    int unsigned guard;
    guard = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] cap);
    drain_ring_traffic();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Default capacity after reset: empty edge, extreme records, peek range
  task automatic test_reset_ring();
    issue_op(FUNC_READ, 32'h1234_5678, 8'd0);
    issue_op(FUNC_PEEK, 32'h0, 8'd0);
    issue_op(FUNC_WRITE, 32'h0000_0000, 8'd254);
    issue_op(FUNC_WRITE, 32'hFFFF_FFFF, 8'd0);
    issue_op(FUNC_PEEK, 32'hFFFF_FFFF, 8'd1);
    issue_op(FUNC_PEEK, 32'h0, 8'd2);
    issue_op(FUNC_READ, 32'h0, 8'd0);
    issue_op(FUNC_READ, 32'h0, 8'd0);
    issue_op(FUNC_READ, 32'h0, 8'd0);
  endtask

  // One-record ring: full after a single write, clear drops the record
  task automatic test_capacity_one();
    set_capacity(8'd1);
    issue_op(FUNC_WRITE, 32'hA5A5_5A5A, 8'd0);
    issue_op(FUNC_WRITE, 32'h5A5A_A5A5, 8'd0);
    issue_op(FUNC_PEEK, 32'h0, 8'd0);
    issue_op(FUNC_READ, 32'h0, 8'd0);
    issue_op(FUNC_WRITE, 32'hC3C3_3C3C, 8'd0);
    issue_op(FUNC_CLEAR, 32'hFFFF_FFFF, 8'd0);
    issue_op(FUNC_READ, 32'h0, 8'd0);
  endtask

  // Zero capacity: single slot, always both empty and full
  task automatic test_capacity_zero();
    set_capacity(8'd0);
    issue_op(FUNC_WRITE, 32'hDEAD_BEEF, 8'd0);
    issue_op(FUNC_READ, 32'h0, 8'd0);
    issue_op(FUNC_PEEK, 32'h0, 8'd0);
    issue_op(FUNC_CLEAR, 32'h0, 8'd0);
  endtask

  // Pointer wrap in a three-slot ring
  task automatic test_wraparound();
    set_capacity(8'd2);
    issue_op(FUNC_WRITE, 32'h0000_0001, 8'd0);
    issue_op(FUNC_WRITE, 32'h0000_0002, 8'd0);
    issue_op(FUNC_READ, 32'h0, 8'd0);
    issue_op(FUNC_WRITE, 32'h0000_0003, 8'd0);
    issue_op(FUNC_PEEK, 32'h0, 8'd1);
    issue_op(FUNC_PEEK, 32'h0, 8'd254);
  endtask

  // Random traffic over several capacities; large rings fill up, then drain
  task automatic test_random_traffic();
    int unsigned cap;
    int unsigned n_ops;
    int unsigned bias;
    int unsigned clear_pct;
    int unsigned r;
    int unsigned hi;
    int unsigned idx;
    bit          big;
    func_e       op;
    bias = 50;
    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       cap = 255;
        1:       cap = 1;
        2:       cap = 3;
        3:       cap = 2;
        4:       cap = $urandom_range(5, 60);
        5:       cap = $urandom_range(128, 254);
        default: cap = $urandom_range(1, 127);
      endcase
      set_capacity(cap[CAP_W-1:0]);
      big       = (cap >= 128);
      n_ops     = big ? 600 : 100;
      clear_pct = big ? 0 : 3;
      for (int i = 0; i < n_ops; i++) begin
        if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
        if (big) begin
          bias = (i < n_ops / 2) ? 97 : 3;
        end else if (i % 40 == 0) begin
          case ($urandom_range(0, 2))
            0:       bias = 85;
            1:       bias = 50;
            default: bias = 15;
          endcase
        end
        r = $urandom_range(0, 99);
        if (r < clear_pct) op = FUNC_CLEAR;
        else if (r < clear_pct + 10) op = FUNC_PEEK;
        else if ($urandom_range(0, 99) < bias) op = FUNC_WRITE;
        else op = FUNC_READ;
        // mostly peeks up to the fill count, sometimes anywhere from 0 to 254
        hi  = (current_fill > 254) ? 254 : current_fill;
        idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 254) : $urandom_range(0, hi);
        issue_op(op, $urandom(), idx[CAP_W-1:0]);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    func_i       <= FUNC_WRITE;
    record_in_i  <= '0;
    peek_index_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_ring();
    test_capacity_one();
    test_capacity_zero();
    test_wraparound();
    test_random_traffic();

    drain_ring_traffic();
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[filelist.f]
design/rrfifo_pkg.sv
design/rrfifo_ptr.sv
design/record_ring_fifo_with_peek.sv
design/rrfifo_chk.sv
test/record_ring_fifo_with_peek_tb.sv
